// File: sv/rmsdb_pkg.sv
// Package for the RMS level meter: widths, constants and sequencer states.
package rmsdb_pkg;

  localparam int SAMPLE_W = 12;
  localparam int SUM_W    = 31;
  localparam int CNT_W    = 8;
  localparam int LEVEL_W  = 16;
  localparam int SQ_W     = 24;          // largest square 4095^2 fits here
  localparam int LOG_FRAC = 24;
  localparam int LOG_INT_W = 5;          // integer part of log2, 0..30
  localparam int LOG_W    = LOG_INT_W + LOG_FRAC;
  localparam int BIT_CNT_W = 5;
  localparam int PROD_W   = 2 * SUM_W;
  localparam int ACC_W    = 64;
  localparam int KHALF_W  = 17;

  localparam logic [CNT_W-1:0]    MAX_WINDOW    = 8'd255;
  localparam logic [SAMPLE_W-1:0] OFFSET_RESET  = 12'd2048;
  localparam logic [LEVEL_W-1:0]  SILENT_LEVEL  = 16'hE000;   // -8192 in Q8
  localparam logic [LOG_INT_W-1:0] TOP_EXP      = 5'd30;

  // 10*log10(2) in Q32, applied as two 17-bit halves
  localparam logic [2*KHALF_W-1:0] DB_PER_OCTAVE_Q32 = 34'd12929139865;
  localparam logic [KHALF_W-1:0] DB_LO = DB_PER_OCTAVE_Q32[KHALF_W-1:0];
  localparam logic [KHALF_W-1:0] DB_HI = DB_PER_OCTAVE_Q32[2*KHALF_W-1:KHALF_W];
  localparam logic [ACC_W-1:0]   ROUND_Q48 = 64'h0000_8000_0000_0000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_SQUARE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_FINISH
  } state_t;

endpackage

// File: sv/rmsdb_ifs.sv
// Channel interfaces of the RMS level meter: samples, results, offset register.
interface rmsdb_in_if;
  logic                               valid;
  logic                               ready;
  logic [rmsdb_pkg::SAMPLE_W-1:0]     sample;
  logic                               last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface rmsdb_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [rmsdb_pkg::LEVEL_W-1:0] level_db;
  logic                               silent;
  logic [rmsdb_pkg::CNT_W-1:0]        window_count;
  logic                               overrun;

  modport source (output valid, output level_db, output silent, output window_count,
                  output overrun, input ready);
  modport sink   (input valid, input level_db, input silent, input window_count,
                  input overrun, output ready);
endinterface

interface rmsdb_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [rmsdb_pkg::SAMPLE_W-1:0]     sample_offset;

  modport source (output valid, output sample_offset, input ready);
  modport sink   (input valid, input sample_offset, output ready);
endinterface

// File: sv/rms_level_to_decibels_unit.sv
// RMS level meter: sum of squares per window, level in dB (Q8) on the last sample.
//
//  channel   | dir | transaction
//  ----------+-----+--------------------------------------------------------
//  in_chan   | in  | sample (12b unsigned), last (window end marker)
//  out_chan  | out | level_db (16b signed Q8), silent, window_count, overrun
//  cfg_chan  | in  | sample_offset (12b), always ready
//
//  Samples not marked last stream back to back while the unit is idle. A last
//  sample with a nonzero sum runs two log2 evaluations (normalize shifts plus 24
//  squaring steps each) and two dB scale partial products on one shared 31x31
//  multiplier, a silent one goes straight to the final load. in_chan is low until
//  the load, stalled by a waiting result; shifts track sum and count leading zeros.
//  Reset (rst_n low, synchronous) sets the offset to midscale and clears the
//  sum, count and overrun flag; there is no clearing pass.
module rms_level_to_decibels_unit (
  input  logic          clk,
  input  logic          rst_n,
  rmsdb_in_if.sink      in_chan,
  rmsdb_out_if.source   out_chan,
  rmsdb_cfg_if.sink     cfg_chan
);

  rmsdb_pkg::state_t state_r, state_nxt;

  // configuration
  logic [rmsdb_pkg::SAMPLE_W-1:0] offset_r;

  // running window
  logic [rmsdb_pkg::SUM_W-1:0] sum_r;
  logic [rmsdb_pkg::CNT_W-1:0] cnt_r;
  logic                        drop_r;

  // window snapshot taken at the last sample
  logic [rmsdb_pkg::CNT_W-1:0] snap_cnt_r;
  logic                        snap_drop_r;
  logic                        snap_silent_r;

  // log unit
  logic [rmsdb_pkg::SUM_W-1:0]     m_r;
  logic [rmsdb_pkg::LOG_INT_W-1:0] p_r;
  logic [rmsdb_pkg::LOG_FRAC-1:0]  frac_r;
  logic [rmsdb_pkg::BIT_CNT_W-1:0] bit_cnt_r;
  logic                            phase_r;     // 0: log of sum, 1: log of count
  logic [rmsdb_pkg::LOG_W-1:0]     ls_r;
  logic [rmsdb_pkg::LOG_W-1:0]     mag_r;
  logic                            neg_r;
  logic [rmsdb_pkg::ACC_W-1:0]     acc_r;

  // output register
  logic                               out_valid_r;
  logic signed [rmsdb_pkg::LEVEL_W-1:0] out_level_r;
  logic                               out_silent_r;
  logic [rmsdb_pkg::CNT_W-1:0]        out_count_r;
  logic                               out_overrun_r;

  // handshake
  logic in_ready;
  logic in_fire;
  logic out_free;

  // accumulate path
  logic signed [rmsdb_pkg::SAMPLE_W:0]       diff;
  logic signed [2*rmsdb_pkg::SAMPLE_W+1:0]   sq_full;
  logic [rmsdb_pkg::SQ_W-1:0]                sq;
  logic [rmsdb_pkg::SUM_W:0]                 sum_add;
  logic                                      full;
  logic [rmsdb_pkg::SUM_W-1:0]               sum_new;
  logic [rmsdb_pkg::CNT_W-1:0]               cnt_new;
  logic                                      drop_new;

  // shared multiplier
  logic [rmsdb_pkg::SUM_W-1:0]  op_a, op_b;
  logic [rmsdb_pkg::PROD_W-1:0] prod;
  logic [rmsdb_pkg::SUM_W:0]    sq_step;
  logic [rmsdb_pkg::SUM_W-1:0]  m_step;
  logic                         bit_step;
  logic [rmsdb_pkg::LOG_FRAC-1:0] frac_step;
  logic [rmsdb_pkg::LOG_W-1:0]  lc_step;
  logic [rmsdb_pkg::LEVEL_W-1:0] r_mag;
  logic [rmsdb_pkg::LEVEL_W-1:0] level_calc;

  assign in_fire  = in_chan.valid && in_ready;
  assign out_free = !out_valid_r || out_chan.ready;

  // ---- per-sample accumulation: subtract offset, square, saturating add ----
  assign diff    = $signed({1'b0, in_chan.sample}) - $signed({1'b0, offset_r});
  assign sq_full = diff * diff;
  assign sq      = sq_full[rmsdb_pkg::SQ_W-1:0];
  assign sum_add = {1'b0, sum_r} + {{(rmsdb_pkg::SUM_W + 1 - rmsdb_pkg::SQ_W){1'b0}}, sq};
  assign full    = (cnt_r == rmsdb_pkg::MAX_WINDOW);

  always_comb begin
    if (full) begin
      sum_new  = sum_r;
      cnt_new  = cnt_r;
      drop_new = 1'b1;
    end else begin
      sum_new  = sum_add[rmsdb_pkg::SUM_W] ? {rmsdb_pkg::SUM_W{1'b1}}
                                           : sum_add[rmsdb_pkg::SUM_W-1:0];
      cnt_new  = cnt_r + 1'b1;
      drop_new = drop_r;
    end
  end

  // ---- shared multiplier: mantissa squaring or dB scale partial product ----
  always_comb begin
    case (state_r)
      rmsdb_pkg::ST_SQUARE: begin
        op_a = m_r;
        op_b = m_r;
      end
      rmsdb_pkg::ST_MUL_LO: begin
        op_a = {{(rmsdb_pkg::SUM_W - rmsdb_pkg::LOG_W){1'b0}}, mag_r};
        op_b = {{(rmsdb_pkg::SUM_W - rmsdb_pkg::KHALF_W){1'b0}}, rmsdb_pkg::DB_LO};
      end
      default: begin
        op_a = {{(rmsdb_pkg::SUM_W - rmsdb_pkg::LOG_W){1'b0}}, mag_r};
        op_b = {{(rmsdb_pkg::SUM_W - rmsdb_pkg::KHALF_W){1'b0}}, rmsdb_pkg::DB_HI};
      end
    endcase
  end

  assign prod = op_a * op_b;

  // one squaring step of the log2 fraction: m in [1,2) as Q30
  assign sq_step   = prod[rmsdb_pkg::PROD_W-1:rmsdb_pkg::SUM_W-1];
  assign bit_step  = sq_step[rmsdb_pkg::SUM_W];
  assign m_step    = bit_step ? sq_step[rmsdb_pkg::SUM_W:1] : sq_step[rmsdb_pkg::SUM_W-1:0];
  assign frac_step = {frac_r[rmsdb_pkg::LOG_FRAC-2:0], bit_step};
  assign lc_step   = {p_r, frac_step};

  assign r_mag      = acc_r[rmsdb_pkg::ACC_W-1:rmsdb_pkg::ACC_W-rmsdb_pkg::LEVEL_W];
  assign level_calc = snap_silent_r ? rmsdb_pkg::SILENT_LEVEL
                    : (neg_r ? (~r_mag + 1'b1) : r_mag);

  // ---- next state ----
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rmsdb_pkg::ST_IDLE: begin
        if (in_fire && in_chan.last) begin
          state_nxt = (sum_new == '0) ? rmsdb_pkg::ST_FINISH : rmsdb_pkg::ST_NORM;
        end
      end
      rmsdb_pkg::ST_NORM: begin
        if (m_r[rmsdb_pkg::SUM_W-1]) begin
          state_nxt = rmsdb_pkg::ST_SQUARE;
        end
      end
      rmsdb_pkg::ST_SQUARE: begin
        if (bit_cnt_r == '0) begin
          state_nxt = phase_r ? rmsdb_pkg::ST_MUL_LO : rmsdb_pkg::ST_NORM;
        end
      end
      rmsdb_pkg::ST_MUL_LO: state_nxt = rmsdb_pkg::ST_MUL_HI;
      rmsdb_pkg::ST_MUL_HI: state_nxt = rmsdb_pkg::ST_FINISH;
      rmsdb_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = rmsdb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rmsdb_pkg::ST_IDLE;
    endcase
  end

  // ---- handshake outputs ----
  always_comb begin
    case (state_r)
      rmsdb_pkg::ST_IDLE: in_ready = 1'b1;
      default:            in_ready = 1'b0;
    endcase
  end

  assign in_chan.ready         = in_ready;
  assign cfg_chan.ready        = 1'b1;
  assign out_chan.valid        = out_valid_r;
  assign out_chan.level_db     = out_level_r;
  assign out_chan.silent       = out_silent_r;
  assign out_chan.window_count = out_count_r;
  assign out_chan.overrun      = out_overrun_r;

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rmsdb_pkg::ST_IDLE;
      offset_r    <= rmsdb_pkg::OFFSET_RESET;
      sum_r       <= '0;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_chan.valid) begin
        offset_r <= cfg_chan.sample_offset;
      end
      if (in_fire) begin
        if (in_chan.last) begin
          sum_r  <= '0;
          cnt_r  <= '0;
          drop_r <= 1'b0;
        end else begin
          sum_r  <= sum_new;
          cnt_r  <= cnt_new;
          drop_r <= drop_new;
        end
      end
      if (state_r == rmsdb_pkg::ST_FINISH && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---- datapath registers ----
  always_ff @(posedge clk) begin
    case (state_r)
      rmsdb_pkg::ST_IDLE: begin
        if (in_fire && in_chan.last) begin
          snap_cnt_r    <= cnt_new;
          snap_drop_r   <= drop_new;
          snap_silent_r <= (sum_new == '0);
          m_r           <= sum_new;
          p_r           <= rmsdb_pkg::TOP_EXP;
          phase_r       <= 1'b0;
        end
      end
      rmsdb_pkg::ST_NORM: begin
        if (m_r[rmsdb_pkg::SUM_W-1]) begin
          bit_cnt_r <= rmsdb_pkg::BIT_CNT_W'(rmsdb_pkg::LOG_FRAC - 1);
          frac_r    <= '0;
        end else begin
          m_r <= {m_r[rmsdb_pkg::SUM_W-2:0], 1'b0};
          p_r <= p_r - 1'b1;
        end
      end
      rmsdb_pkg::ST_SQUARE: begin
        bit_cnt_r <= bit_cnt_r - 1'b1;
        frac_r    <= frac_step;
        if (bit_cnt_r != '0) begin
          m_r <= m_step;
        end else if (!phase_r) begin
          ls_r    <= lc_step;
          m_r     <= {{(rmsdb_pkg::SUM_W - rmsdb_pkg::CNT_W){1'b0}}, snap_cnt_r};
          p_r     <= rmsdb_pkg::TOP_EXP;
          phase_r <= 1'b1;
        end else begin
          neg_r <= (ls_r < lc_step);
          mag_r <= (ls_r < lc_step) ? (lc_step - ls_r) : (ls_r - lc_step);
        end
      end
      rmsdb_pkg::ST_MUL_LO: begin
        acc_r <= {{(rmsdb_pkg::ACC_W - rmsdb_pkg::PROD_W){1'b0}}, prod} + rmsdb_pkg::ROUND_Q48;
      end
      rmsdb_pkg::ST_MUL_HI: begin
        acc_r <= acc_r
               + ({{(rmsdb_pkg::ACC_W - rmsdb_pkg::PROD_W){1'b0}}, prod} << rmsdb_pkg::KHALF_W);
      end
      rmsdb_pkg::ST_FINISH: begin
        if (out_free) begin
          out_level_r   <= level_calc;
          out_silent_r  <= snap_silent_r;
          out_count_r   <= snap_cnt_r;
          out_overrun_r <= snap_drop_r;
        end
      end
      default: begin
      end
    endcase
  end

  // ---- assertions ----
  // a silent result always carries the floor level
  a_silent_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_silent_r) |-> (out_level_r == rmsdb_pkg::SILENT_LEVEL))
    else $error("silent result without floor level");

  // dropped samples only happen on a full window
  a_overrun_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_overrun_r) |-> (out_count_r == rmsdb_pkg::MAX_WINDOW))
    else $error("overrun with partial window");

  // squaring steps run on a normalized mantissa
  a_mant_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rmsdb_pkg::ST_SQUARE) |-> m_r[rmsdb_pkg::SUM_W-1])
    else $error("mantissa not normalized in squaring step");

  // a finished calculation lands in the output register
  a_finish_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rmsdb_pkg::ST_FINISH && out_free) |=> out_valid_r)
    else $error("result not loaded after calculation");

  // a last sample always blocks intake for the next cycle
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_chan.last) |=> !in_chan.ready)
    else $error("input ready right after window end");

endmodule
